// File: rtl/usb_endpoint_transfer_manager_top_macros.svh
// ----------------------------------------------------------------------------
// USB endpoint transfer manager assertion macros
// Concurrent assertion wrappers, removed when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef USB_ENDPOINT_TRANSFER_MANAGER_TOP_MACROS_SVH
`define USB_ENDPOINT_TRANSFER_MANAGER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define USBETM_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("usbetm assertion failed");
`define USBETM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("usbetm assertion failed");
`else
`define USBETM_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define USBETM_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/usbetm_pkg.sv
// ----------------------------------------------------------------------------
// USB endpoint transfer manager package
// Shared constants, codes and transfer structures.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package usbetm_pkg;

    localparam int ENDPOINT_COUNT = 16;
    localparam int EP_W = (ENDPOINT_COUNT > 1) ? $clog2(ENDPOINT_COUNT) : 1;
    localparam logic [4:0] EP_COUNT_W = 5'(ENDPOINT_COUNT);

    localparam logic [3:0] ACT_ENABLE      = 4'd0;
    localparam logic [3:0] ACT_DISABLE     = 4'd1;
    localparam logic [3:0] ACT_ARM_RX      = 4'd2;
    localparam logic [3:0] ACT_QUEUE_TX    = 4'd3;
    localparam logic [3:0] ACT_RX_DONE     = 4'd4;
    localparam logic [3:0] ACT_TX_DONE     = 4'd5;
    localparam logic [3:0] ACT_BUS_RESET   = 4'd6;
    localparam logic [3:0] ACT_BUS_ERROR   = 4'd7;
    localparam logic [3:0] ACT_SET_TOGGLE  = 4'd8;
    localparam logic [3:0] ACT_STALL       = 4'd9;
    localparam logic [3:0] ACT_UNSTALL     = 4'd10;
    localparam logic [3:0] ACT_CANCEL_TX   = 4'd11;
    localparam logic [3:0] ACT_SET_ADDRESS = 4'd12;

    localparam logic [2:0] EV_DONE  = 3'd0;
    localparam logic [2:0] EV_ERR   = 3'd1;
    localparam logic [2:0] EV_RXARM = 3'd2;
    localparam logic [2:0] EV_TXARM = 3'd3;
    localparam logic [2:0] EV_RXDEL = 3'd4;
    localparam logic [2:0] EV_TXCPL = 3'd5;
    localparam logic [2:0] EV_RESET = 3'd6;

    localparam logic [1:0] EPT_IN      = 2'd0;
    localparam logic [1:0] EPT_OUT     = 2'd1;
    localparam logic [1:0] EPT_INVALID = 2'd3;

    localparam logic [3:0] CTRL_IN    = 4'b0101;
    localparam logic [3:0] CTRL_OUT   = 4'b1001;
    localparam logic [3:0] CTRL_BIDIR = 4'b1101;
    localparam logic [3:0] CTRL_STALL = 4'b0010;

    localparam logic [1:0] CFG_MAX_PACKET = 2'd0;
    localparam logic [1:0] CFG_RX_BUFFER  = 2'd1;

    localparam logic [6:0] MPS_MIN   = 7'd8;
    localparam logic [6:0] MPS_MAX   = 7'd64;
    localparam logic [6:0] MPS_RESET = 7'd64;
    localparam logic [9:0] RBS_RESET = 10'd64;

    typedef struct packed {
        logic [3:0]  action;
        logic [3:0]  endpoint;
        logic [1:0]  endpoint_type;
        logic [15:0] transfer_length;
        logic        extended;
        logic        setup_token;
        logic        rx_toggle;
        logic [9:0]  done_byte_count;
        logic        new_toggle;
        logic [6:0]  new_address;
    } req_t;

    typedef struct packed {
        logic [2:0]  event_res;
        logic [3:0]  event_endpoint;
        logic        descriptor_toggle;
        logic [9:0]  descriptor_length;
        logic [15:0] chunk_offset;
        logic        delivered_setup;
        logic [3:0]  endpoint_control;
        logic        endpoint_enabled;
        logic        endpoint_stalled;
        logic [6:0]  device_address;
    } rsp_t;

    typedef struct packed {
        logic [6:0] pkt_size;
        logic [9:0] receive_buffer_size;
    } cfg_t;

endpackage

// File: rtl/usb_endpoint_transfer_manager_top.sv
// ----------------------------------------------------------------------------
// USB endpoint transfer manager
// Per-endpoint toggle, descriptor ownership and transmit segmentation.
// ----------------------------------------------------------------------------
// One item is accepted per cycle while the m_ side is not stalled, and each
// gives exactly one result on the m_ side after passing through an input
// register, one pass through the endpoint decode against the per-endpoint
// state flops, then the result register. A stalled result holds the input
// register; the s_ side stays ready while the result stage can drain.
// Configuration writes are taken in any cycle; no clearing pass follows reset.
`timescale 1ns / 1ps
`include "usb_endpoint_transfer_manager_top_macros.svh"

module usb_endpoint_transfer_manager_top
    import usbetm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [3:0]  s_action,
    input  logic [3:0]  s_endpoint,
    input  logic [1:0]  s_endpoint_type,
    input  logic [15:0] s_transfer_length,
    input  logic        s_extended,
    input  logic        s_setup_token,
    input  logic        s_rx_toggle,
    input  logic [9:0]  s_done_byte_count,
    input  logic        s_new_toggle,
    input  logic [6:0]  s_new_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [3:0]  m_event_endpoint,
    output logic        m_descriptor_toggle,
    output logic [9:0]  m_descriptor_length,
    output logic [15:0] m_chunk_offset,
    output logic        m_delivered_setup,
    output logic [3:0]  m_endpoint_control,
    output logic        m_endpoint_enabled,
    output logic        m_endpoint_stalled,
    output logic [6:0]  m_device_address,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    req_t in_reg;
    logic in_vld_reg, in_vld_next;
    rsp_t out_reg;
    logic out_vld_reg, out_vld_next;
    cfg_t cfg_reg;
    rsp_t rsp;
    logic out_adv, fire, s_fire, out_ep_bad;

    assign out_adv      = !out_vld_reg || m_ready;
    assign fire         = in_vld_reg && out_adv;
    assign s_ready      = !in_vld_reg || out_adv;
    assign s_fire       = s_valid && s_ready;
    assign in_vld_next  = s_fire || (in_vld_reg && !out_adv);
    assign out_vld_next = out_adv ? in_vld_reg : out_vld_reg;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            cfg_reg.pkt_size            <= MPS_RESET;
            cfg_reg.receive_buffer_size <= RBS_RESET;
        end else begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_index == CFG_MAX_PACKET) begin
                cfg_reg.pkt_size <= cfg_data[6:0];
            end
            if (cfg_valid && cfg_index == CFG_RX_BUFFER) begin
                cfg_reg.receive_buffer_size <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_reg.action          <= s_action;
            in_reg.endpoint        <= s_endpoint;
            in_reg.endpoint_type   <= s_endpoint_type;
            in_reg.transfer_length <= s_transfer_length;
            in_reg.extended        <= s_extended;
            in_reg.setup_token     <= s_setup_token;
            in_reg.rx_toggle       <= s_rx_toggle;
            in_reg.done_byte_count <= s_done_byte_count;
            in_reg.new_toggle      <= s_new_toggle;
            in_reg.new_address     <= s_new_address;
        end
        if (fire) begin
            out_reg <= rsp;
        end
    end

    usbetm_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .req     (in_reg),
        .cfg     (cfg_reg),
        .rsp     (rsp)
    );

    assign m_valid             = out_vld_reg;
    assign m_event_res         = out_reg.event_res;
    assign m_event_endpoint    = out_reg.event_endpoint;
    assign m_descriptor_toggle = out_reg.descriptor_toggle;
    assign m_descriptor_length = out_reg.descriptor_length;
    assign m_chunk_offset      = out_reg.chunk_offset;
    assign m_delivered_setup   = out_reg.delivered_setup;
    assign m_endpoint_control  = out_reg.endpoint_control;
    assign m_endpoint_enabled  = out_reg.endpoint_enabled;
    assign m_endpoint_stalled  = out_reg.endpoint_stalled;
    assign m_device_address    = out_reg.device_address;

    assign out_ep_bad = ({1'b0, out_reg.event_endpoint} >= EP_COUNT_W);

    `USBETM_ASSERT_IMPL(a_bad_ep_no_flags, aclk, aresetn,
        out_vld_reg && out_ep_bad, out_reg.endpoint_control == 4'd0 && !out_reg.endpoint_enabled)
    `USBETM_ASSERT_IMPL(a_offset_only_on_tx_arm, aclk, aresetn,
        out_vld_reg && out_reg.event_res != EV_TXARM, out_reg.chunk_offset == 16'd0)
    `USBETM_ASSERT_NEXT(a_input_held_on_stall, aclk, aresetn,
        in_vld_reg && !out_adv, in_vld_reg && $stable(in_reg))

endmodule

// File: rtl/usbetm_engine.sv
// ----------------------------------------------------------------------------
// USB endpoint transfer manager engine
// Per-endpoint state flops and the single-pass action decode.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "usb_endpoint_transfer_manager_top_macros.svh"

module usbetm_engine
    import usbetm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic fire,
    input  req_t req,
    input  cfg_t cfg,
    output rsp_t rsp
);

    logic                      en_reg   [ENDPOINT_COUNT];
    logic [ENDPOINT_COUNT-1:0] tog_reg;
    logic                      rxo_reg  [ENDPOINT_COUNT];
    logic                      txo_reg  [ENDPOINT_COUNT];
    logic [3:0]                ctrl_reg [ENDPOINT_COUNT];
    logic                      ext_reg  [ENDPOINT_COUNT];
    logic [15:0]               rem_reg  [ENDPOINT_COUNT];
    logic [15:0]               off_reg  [ENDPOINT_COUNT];
    logic [6:0]                addr_reg;

    logic [EP_W-1:0] ep_idx;
    logic            ep_ok;
    logic            en_c, tog_c, rxo_c, txo_c, ext_c;
    logic [3:0]      ctrl_c;
    logic [15:0]     rem_c, off_c;
    logic            en_next, tog_next, rxo_next, txo_next, ext_next;
    logic [3:0]      ctrl_next;
    logic [15:0]     rem_next, off_next;
    logic [6:0]      addr_next;
    logic            wr, clr_tog;
    logic [6:0]      lim;
    logic [15:0]     lim16, cnt16, rem_sub, off_add, arm_len;
    logic            arm_ext, arm_ext_n, tog1;
    logic [9:0]      arm_chunk;
    logic [2:0]      ev;
    logic            dtog, dsetup;
    logic [9:0]      dlen;
    logic [15:0]     doff;

    assign ep_idx = req.endpoint[EP_W-1:0];
    assign ep_ok  = ({1'b0, req.endpoint} < EP_COUNT_W);
    assign en_c   = en_reg[ep_idx];
    assign tog_c  = tog_reg[ep_idx];
    assign rxo_c  = rxo_reg[ep_idx];
    assign txo_c  = txo_reg[ep_idx];
    assign ext_c  = ext_reg[ep_idx];
    assign ctrl_c = ctrl_reg[ep_idx];
    assign rem_c  = rem_reg[ep_idx];
    assign off_c  = off_reg[ep_idx];

    always_comb begin
        lim = cfg.pkt_size;
        if (lim < MPS_MIN) begin
            lim = MPS_MIN;
        end else if (lim > MPS_MAX) begin
            lim = MPS_MAX;
        end
    end

    assign lim16   = {9'd0, lim};
    assign cnt16   = {6'd0, req.done_byte_count};
    assign rem_sub = rem_c - cnt16;
    assign off_add = off_c + cnt16;
    assign tog1    = req.setup_token ? 1'b0 : tog_c;
    assign arm_len = (req.action == ACT_TX_DONE) ? rem_sub : req.transfer_length;
    assign arm_ext = (req.action == ACT_TX_DONE) ? (rem_sub >= lim16) : req.extended;

    always_comb begin
        if (arm_len < lim16) begin
            arm_ext_n = 1'b0;
        end else if (arm_len == lim16) begin
            arm_ext_n = arm_ext;
        end else begin
            arm_ext_n = 1'b1;
        end
        arm_chunk = (arm_len <= lim16) ? arm_len[9:0] : {3'd0, lim};
    end

    always_comb begin
        en_next   = en_c;
        tog_next  = tog_c;
        rxo_next  = rxo_c;
        txo_next  = txo_c;
        ext_next  = ext_c;
        ctrl_next = ctrl_c;
        rem_next  = rem_c;
        off_next  = off_c;
        addr_next = addr_reg;
        wr        = 1'b0;
        clr_tog   = 1'b0;
        ev        = EV_DONE;
        dtog      = 1'b0;
        dlen      = '0;
        doff      = '0;
        dsetup    = 1'b0;
        if (req.action == ACT_BUS_RESET) begin
            addr_next = '0;
            clr_tog   = 1'b1;
            ev        = EV_RESET;
        end else if (req.action == ACT_SET_ADDRESS) begin
            addr_next = req.new_address;
        end else if (req.action == ACT_BUS_ERROR || req.action > ACT_SET_ADDRESS || !ep_ok) begin
            ev = EV_ERR;
        end else begin
            wr = 1'b1;
            case (req.action)
                ACT_ENABLE: begin
                    if (req.endpoint_type == EPT_INVALID) begin
                        ev = EV_ERR;
                    end else begin
                        en_next  = 1'b1;
                        tog_next = 1'b0;
                        case (req.endpoint_type)
                            EPT_IN:  ctrl_next = CTRL_IN;
                            EPT_OUT: ctrl_next = CTRL_OUT;
                            default: ctrl_next = CTRL_BIDIR;
                        endcase
                        if (rxo_c) begin
                            ev = EV_ERR;
                        end else begin
                            rxo_next = 1'b1;
                            ev       = EV_RXARM;
                            dlen     = cfg.receive_buffer_size;
                        end
                    end
                end
                ACT_DISABLE: begin
                    en_next   = 1'b0;
                    ctrl_next = '0;
                    rxo_next  = 1'b0;
                    txo_next  = 1'b0;
                end
                ACT_ARM_RX: begin
                    if (!en_c || rxo_c) begin
                        ev = EV_ERR;
                    end else begin
                        rxo_next = 1'b1;
                        ev       = EV_RXARM;
                        dtog     = tog_c;
                        dlen     = cfg.receive_buffer_size;
                    end
                end
                ACT_QUEUE_TX: begin
                    if (txo_c || !en_c || (req.transfer_length > lim16 && !req.extended)) begin
                        ev = EV_ERR;
                    end else begin
                        off_next = '0;
                        rem_next = arm_len;
                        ext_next = arm_ext_n;
                        txo_next = 1'b1;
                        dlen     = arm_chunk;
                        ev       = EV_TXARM;
                        dtog     = tog_c;
                    end
                end
                ACT_RX_DONE: begin
                    if (!en_c) begin
                        ev = EV_ERR;
                    end else if (req.rx_toggle == tog1) begin
                        tog_next = ~tog1;
                        rxo_next = 1'b0;
                        ev       = EV_RXDEL;
                        dlen     = req.done_byte_count;
                        dsetup   = req.setup_token;
                    end else begin
                        tog_next = tog1;
                        rxo_next = 1'b1;
                        ev       = EV_RXARM;
                        dtog     = tog1;
                        dlen     = cfg.receive_buffer_size;
                    end
                end
                ACT_TX_DONE: begin
                    if (!en_c) begin
                        ev = EV_ERR;
                    end else begin
                        txo_next = 1'b0;
                        tog_next = ~tog_c;
                        if (!ext_c) begin
                            ev = EV_TXCPL;
                        end else if (rem_c < cnt16) begin
                            ext_next = 1'b0;
                            rem_next = '0;
                            ev       = EV_ERR;
                        end else begin
                            off_next = off_add;
                            rem_next = arm_len;
                            ext_next = arm_ext_n;
                            txo_next = 1'b1;
                            dlen     = arm_chunk;
                            ev       = EV_TXARM;
                            dtog     = ~tog_c;
                            doff     = off_add;
                        end
                    end
                end
                ACT_SET_TOGGLE: begin
                    if (!en_c) begin
                        ev = EV_ERR;
                    end else begin
                        tog_next = req.new_toggle;
                    end
                end
                ACT_STALL: begin
                    ctrl_next = ctrl_c | CTRL_STALL;
                end
                ACT_UNSTALL: begin
                    ctrl_next = ctrl_c & ~CTRL_STALL;
                end
                ACT_CANCEL_TX: begin
                    if (!txo_c) begin
                        ev = EV_ERR;
                    end
                    txo_next = 1'b0;
                end
                default: begin
                    ev = EV_ERR;
                end
            endcase
        end
    end

    always_comb begin
        rsp.event_res         = ev;
        rsp.event_endpoint    = req.endpoint;
        rsp.descriptor_toggle = dtog;
        rsp.descriptor_length = dlen;
        rsp.chunk_offset      = doff;
        rsp.delivered_setup   = dsetup;
        rsp.endpoint_control  = ep_ok ? ctrl_next : 4'd0;
        rsp.endpoint_enabled  = ep_ok & en_next;
        rsp.endpoint_stalled  = ep_ok & ctrl_next[1];
        rsp.device_address    = addr_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tog_reg  <= '0;
            addr_reg <= '0;
            for (int i = 0; i < ENDPOINT_COUNT; i++) begin
                en_reg[i]   <= 1'b0;
                rxo_reg[i]  <= 1'b0;
                txo_reg[i]  <= 1'b0;
                ext_reg[i]  <= 1'b0;
                ctrl_reg[i] <= '0;
                rem_reg[i]  <= '0;
                off_reg[i]  <= '0;
            end
        end else if (fire) begin
            addr_reg <= addr_next;
            if (clr_tog) begin
                tog_reg <= '0;
            end
            if (wr) begin
                en_reg[ep_idx]   <= en_next;
                tog_reg[ep_idx]  <= tog_next;
                rxo_reg[ep_idx]  <= rxo_next;
                txo_reg[ep_idx]  <= txo_next;
                ext_reg[ep_idx]  <= ext_next;
                ctrl_reg[ep_idx] <= ctrl_next;
                rem_reg[ep_idx]  <= rem_next;
                off_reg[ep_idx]  <= off_next;
            end
        end
    end

    `USBETM_ASSERT_NEXT(a_bus_reset_clears_toggles, aclk, aresetn,
        fire && req.action == ACT_BUS_RESET, tog_reg == '0)
    `USBETM_ASSERT_IMPL(a_chunk_within_limit, aclk, aresetn,
        fire && ev == EV_TXARM, dlen <= {3'd0, lim})
    `USBETM_ASSERT_NEXT(a_disable_clears_enable, aclk, aresetn,
        fire && ep_ok && req.action == ACT_DISABLE, !en_reg[$past(ep_idx)])

endmodule
